// ===== design/mmi_pkg.sv =====
// Shared types and constants for the integer matrix multiplier.
package mmi_pkg;

    localparam int MAX_DIM_DEFAULT = 8;
    localparam int DIM_W = 4;
    localparam int IDX_W = 3;
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_START  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_LEN = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    // Control handed from the sequencer into the head of the MAC chain.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             final_k;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } mac_ctl_t;

endpackage

// ===== design/matrix_multiply_int.sv =====
// Top level of the integer matrix multiplier: stores, sequencer, MAC chain, output.
//
// Loads are accepted back to back while the block is idle. A start walks C in row-major
// order on a single multiply-accumulate chain (operand read, multiply, accumulate,
// three cells), issuing one term per cycle while issue is not held. After the final
// term of a result the sequencer holds issue while that term passes issue_reg and the
// three cells into the output register and until it is taken, so the results of a
// start come one after another from that one multiplier. Zero dimensions give a single
// error beat. Dimensions above min(MAX_DIM, 8) are clamped; loads outside that bound
// are dropped. No new item is accepted until all results of a start have been taken.
module matrix_multiply_int #(
    parameter int MAX_DIM = mmi_pkg::MAX_DIM_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: cmd[1:0], row[4:2], col[7:5], value[39:8]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: out_row[2:0], out_col[5:3], sum[37:6], pad
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    // m_tuser: error
    output logic        m_tuser
);

    localparam int CAP    = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam int DEPTH  = 64;
    localparam int AW     = 6;
    localparam int IW     = mmi_pkg::IDX_W;
    localparam int DW     = mmi_pkg::DIM_W;
    localparam int VW     = mmi_pkg::VAL_W;
    localparam logic [DW-1:0] CAP_D = DW'(CAP);

    // Configuration registers
    logic [DW-1:0] rows_a_reg, inner_len_reg, cols_b_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DW'(1);
            inner_len_reg <= DW'(1);
            cols_b_reg    <= DW'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                mmi_pkg::REG_ROWS_A:    rows_a_reg    <= pwdata[DW-1:0];
                mmi_pkg::REG_INNER_LEN: inner_len_reg <= pwdata[DW-1:0];
                mmi_pkg::REG_COLS_B:    cols_b_reg    <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            mmi_pkg::REG_ROWS_A:    prdata = 32'(rows_a_reg);
            mmi_pkg::REG_INNER_LEN: prdata = 32'(inner_len_reg);
            mmi_pkg::REG_COLS_B:    prdata = 32'(cols_b_reg);
            default:                prdata = '0;
        endcase
    end

    // Input beat fields
    mmi_pkg::cmd_t in_cmd;
    logic [IW-1:0] in_row, in_col;
    logic [VW-1:0] in_val;
    logic          in_acc;
    assign in_cmd = mmi_pkg::cmd_t'(s_tdata[1:0]);
    assign in_row = s_tdata[4:2];
    assign in_col = s_tdata[7:5];
    assign in_val = s_tdata[39:8];

    typedef enum logic [1:0] { S_IDLE, S_RUN, S_DRAIN, S_ERR } state_t;
    state_t        state_reg;
    logic [DW-1:0] m_reg, n_reg, p_reg;
    logic [IW-1:0] i_reg, j_reg, k_reg;
    logic          busy_issue;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // Stores: written on load, read at (i,k) and (k,j)
    logic [VW-1:0] a_mem [DEPTH];
    logic [VW-1:0] b_mem [DEPTH];
    logic [VW-1:0] a_rd_reg, b_rd_reg;
    logic          ld_ok;
    assign ld_ok = (32'(in_row) < CAP) && (32'(in_col) < CAP);

    always_ff @(posedge clk)
    begin
        if (in_acc && ld_ok && in_cmd == mmi_pkg::CMD_LOAD_A)
            a_mem[{in_row, in_col}] <= in_val;
        if (in_acc && ld_ok && in_cmd == mmi_pkg::CMD_LOAD_B)
            b_mem[{in_row, in_col}] <= in_val;
        a_rd_reg <= a_mem[AW'({i_reg, k_reg})];
        b_rd_reg <= b_mem[AW'({k_reg, j_reg})];
    end

    // Sequencer: walk i, j, k; one term enters the chain each cycle unless issue is held
    mmi_pkg::mac_ctl_t issue_ctl, issue_reg;
    logic              k_end, j_end, i_end;
    logic              chain_busy;
    logic              out_full_reg;
    logic              stall_hold;
    logic [2:0]        pend;

    assign busy_issue = (state_reg == S_RUN) && !out_full_reg && !stall_hold;
    assign k_end = ({1'b0, k_reg} == DW'(n_reg - 1'b1));
    assign j_end = ({1'b0, j_reg} == DW'(p_reg - 1'b1));
    assign i_end = ({1'b0, i_reg} == DW'(m_reg - 1'b1));

    always_comb
    begin
        issue_ctl         = '0;
        issue_ctl.valid   = busy_issue;
        issue_ctl.first   = (k_reg == '0);
        issue_ctl.final_k = k_end;
        issue_ctl.row     = i_reg;
        issue_ctl.col     = j_reg;
        issue_ctl.last    = k_end && j_end && i_end;
    end

    function automatic logic [DW-1:0] clamp(input logic [DW-1:0] d);
        return (d > CAP_D) ? CAP_D : d;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg <= '0; j_reg <= '0; k_reg <= '0;
            m_reg <= '0; n_reg <= '0; p_reg <= '0;
            issue_reg <= '0;
        end
        else
        begin
            issue_reg <= issue_ctl;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && in_cmd == mmi_pkg::CMD_START)
                    begin
                        m_reg <= clamp(rows_a_reg);
                        n_reg <= clamp(inner_len_reg);
                        p_reg <= clamp(cols_b_reg);
                        i_reg <= '0; j_reg <= '0; k_reg <= '0;
                        if (rows_a_reg == '0 || inner_len_reg == '0 || cols_b_reg == '0)
                            state_reg <= S_ERR;
                        else
                            state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (busy_issue)
                    begin
                        if (!k_end)
                            k_reg <= k_reg + 1'b1;
                        else
                        begin
                            k_reg <= '0;
                            if (!j_end)
                                j_reg <= j_reg + 1'b1;
                            else
                            begin
                                j_reg <= '0;
                                if (!i_end)
                                    i_reg <= i_reg + 1'b1;
                                else
                                    state_reg <= S_DRAIN;
                            end
                        end
                    end
                end
                S_DRAIN:
                begin
                    if (!chain_busy && !out_full_reg)
                        state_reg <= S_IDLE;
                end
                S_ERR:
                begin
                    if (!out_full_reg)
                        state_reg <= S_DRAIN;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // MAC chain: operand cell, multiply cell, accumulate cell
    mmi_pkg::mac_ctl_t c1_ctl, c2_ctl, c3_ctl;
    logic [VW-1:0]     c1_x, c1_y, c2_x, c2_y, c3_x, c3_y;

    mmi_mac_cell #(.MODE(0)) u_cell_op (
        .clk(clk), .rst_n(rst_n), .ctl_in(issue_reg), .x_in(a_rd_reg), .y_in(b_rd_reg),
        .ctl_out(c1_ctl), .x_out(c1_x), .y_out(c1_y));
    mmi_mac_cell #(.MODE(1)) u_cell_mul (
        .clk(clk), .rst_n(rst_n), .ctl_in(c1_ctl), .x_in(c1_x), .y_in(c1_y),
        .ctl_out(c2_ctl), .x_out(c2_x), .y_out(c2_y));
    mmi_mac_cell #(.MODE(2)) u_cell_acc (
        .clk(clk), .rst_n(rst_n), .ctl_in(c2_ctl), .x_in(c2_x), .y_in(c2_y),
        .ctl_out(c3_ctl), .x_out(c3_x), .y_out(c3_y));

    // Terms in flight between issue and accumulate (issue_reg, op, mul, acc)
    assign pend = 3'(issue_reg.valid) + 3'(c1_ctl.valid) + 3'(c2_ctl.valid)
                + 3'(c3_ctl.valid);
    assign chain_busy = (pend != '0) || busy_issue;

    // Hold issue while the final term of a result is still on its way to the output
    assign stall_hold = (issue_reg.valid && issue_reg.final_k)
                     || (c1_ctl.valid && c1_ctl.final_k)
                     || (c2_ctl.valid && c2_ctl.final_k)
                     || (c3_ctl.valid && c3_ctl.final_k);

    // Output register; the sequencer stalls while a result waits so terms never overrun it
    logic [IW-1:0] o_row_reg, o_col_reg;
    logic [VW-1:0] o_sum_reg;
    logic          o_last_reg, o_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (c3_ctl.valid && c3_ctl.final_k)
            out_full_reg <= 1'b1;
        else if (state_reg == S_ERR && !out_full_reg)
            out_full_reg <= 1'b1;
        else if (m_tready)
            out_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (c3_ctl.valid && c3_ctl.final_k)
        begin
            o_row_reg  <= c3_ctl.row;
            o_col_reg  <= c3_ctl.col;
            o_sum_reg  <= c3_y;
            o_last_reg <= c3_ctl.last;
            o_err_reg  <= 1'b0;
        end
        else if (state_reg == S_ERR && !out_full_reg)
        begin
            o_row_reg  <= '0;
            o_col_reg  <= '0;
            o_sum_reg  <= '0;
            o_last_reg <= 1'b1;
            o_err_reg  <= 1'b1;
        end
    end

    assign m_tvalid = out_full_reg;
    assign m_tdata  = {2'b00, o_sum_reg, o_col_reg, o_row_reg};
    assign m_tlast  = o_last_reg;
    assign m_tuser  = o_err_reg;

    // Cell outputs that pass through without further use
    logic unused_ok;
    assign unused_ok = (|c3_x) ^ (|c1_y ^ |c2_y);

endmodule

// ===== design/mmi_mac_cell.sv =====
// One stage of the multiply-accumulate chain: register, multiply, or accumulate.
module mmi_mac_cell #(
    parameter int MODE = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mmi_pkg::mac_ctl_t               ctl_in,
    input  logic [mmi_pkg::VAL_W-1:0]       x_in,
    input  logic [mmi_pkg::VAL_W-1:0]       y_in,
    output mmi_pkg::mac_ctl_t               ctl_out,
    output logic [mmi_pkg::VAL_W-1:0]       x_out,
    output logic [mmi_pkg::VAL_W-1:0]       y_out
);

    mmi_pkg::mac_ctl_t            ctl_reg;
    logic [mmi_pkg::VAL_W-1:0]    x_reg;
    logic [mmi_pkg::VAL_W-1:0]    y_reg;
    logic [mmi_pkg::VAL_W-1:0]    x_next;
    logic [mmi_pkg::VAL_W-1:0]    y_next;
    logic [2*mmi_pkg::VAL_W-1:0]  prod;

    // MODE 0 holds operands, 1 multiplies, 2 accumulates product in y
    assign prod = 64'(x_in) * 64'(y_in);

    always_comb
    begin
        x_next = x_in;
        y_next = y_in;
        if (MODE == 1)
        begin
            x_next = prod[mmi_pkg::VAL_W-1:0];
        end
        else if (MODE == 2)
        begin
            if (ctl_in.valid)
                y_next = ctl_in.first ? x_in : (y_reg + x_in);
            else
                y_next = y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;

endmodule

// ===== design/mmi_checker.sv =====
// Port-level assertions for the matrix multiplier, bound to the top level.
module mmi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // An error beat is always a final, zero beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("error beat malformed");

    // No new input while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled beat changed");

endmodule

bind matrix_multiply_int mmi_checker u_mmi_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser));

// ===== bench/matrix_multiply_int_test.sv =====
// Self-checking bench for the integer matrix multiplier: loads, starts, and APB dimension setup.
module matrix_multiply_int_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 2000000;

    // Expected products for the multiplier, checked in order of arrival
    class product_board;
        logic [31:0] a_mat [8][8];
        logic [31:0] b_mat [8][8];
        logic [3:0] dim_m, dim_n, dim_p;
        logic [39:0] want_data [$];
        logic want_last [$];
        logic want_err [$];
        int errors;
        int shown;

        function new();
            dim_m = 1;
            dim_n = 1;
            dim_p = 1;
            errors = 0;
            shown = 0;
        endfunction

        function void note_beat(logic [39:0] beat);
            mmi_pkg::cmd_t op;
            logic [2:0] r, c;
            logic [31:0] v, acc;
            int m, n, p;
            op = mmi_pkg::cmd_t'(beat[1:0]);
            r = beat[4:2];
            c = beat[7:5];
            v = beat[39:8];
            if (op == mmi_pkg::CMD_LOAD_A)
                a_mat[r][c] = v;
            else if (op == mmi_pkg::CMD_LOAD_B)
                b_mat[r][c] = v;
            else if (op == mmi_pkg::CMD_START)
            begin
                m = (dim_m > 8) ? 8 : dim_m;
                n = (dim_n > 8) ? 8 : dim_n;
                p = (dim_p > 8) ? 8 : dim_p;
                if (m == 0 || n == 0 || p == 0)
                begin
                    want_data.push_back('0);
                    want_last.push_back(1'b1);
                    want_err.push_back(1'b1);
                end
                else
                begin
                    for (int i = 0; i < m; i++)
                        for (int j = 0; j < p; j++)
                        begin
                            acc = '0;
                            for (int k = 0; k < n; k++)
                                acc = acc + a_mat[i][k] * b_mat[k][j];
                            want_data.push_back({2'b0, acc, j[2:0], i[2:0]});
                            want_last.push_back(i == m - 1 && j == p - 1);
                            want_err.push_back(1'b0);
                        end
                end
            end
        endfunction

        function void check_beat(logic [39:0] d, logic l, logic e);
            logic [39:0] xd;
            logic xl, xe;
            if (want_data.size() == 0)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("unexpected result beat data=%h last=%b err=%b", d, l, e);
                end
                return;
            end
            xd = want_data.pop_front();
            xl = want_last.pop_front();
            xe = want_err.pop_front();
            if (d[37:0] !== xd[37:0] || l !== xl || e !== xe)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("mismatch: expected row=%0d col=%0d sum=%h last=%b err=%b",
                        xd[2:0], xd[5:3], xd[37:6], xl, xe);
                    $display("          actual   row=%0d col=%0d sum=%h last=%b err=%b",
                        d[2:0], d[5:3], d[37:6], l, e);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic s_tvalid;
    logic s_tready;
    // s_tdata: cmd[1:0], row[4:2], col[7:5], value[39:8]
    logic [39:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    // m_tdata: out_row[2:0], out_col[5:3], sum[37:6], pad
    logic [39:0] m_tdata;
    logic m_tlast;
    // m_tuser: error
    logic m_tuser;

    product_board board;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off;
    bit done;

    matrix_multiply_int DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Write one dimension register through a setup and an access cycle
    task automatic write_dim(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == mmi_pkg::REG_ROWS_A)
            board.dim_m = val[3:0];
        else if (idx == mmi_pkg::REG_INNER_LEN)
            board.dim_n = val[3:0];
        else
            board.dim_p = val[3:0];
        @(posedge clk);
    endtask

    task automatic set_dims(int m, int n, int p);
        write_dim(mmi_pkg::REG_ROWS_A, m);
        write_dim(mmi_pkg::REG_INNER_LEN, n);
        write_dim(mmi_pkg::REG_COLS_B, p);
    endtask

    // Offer one beat, with random idle cycles, and hold it until taken;
    // valid stays up so a following beat can go out back to back
    task automatic send_beat(mmi_pkg::cmd_t op, int r, int c, logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {v, c[2:0], r[2:0], op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_beat(s_tdata);
    endtask

    // Drop valid, wait for all results, then let the pipeline drain before a register write
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.want_data.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'hffffffff;
            3: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    // Fill the used part of A and B so a start never reads an unwritten entry
    task automatic load_mats(int m, int n, int p);
        for (int i = 0; i < m; i++)
            for (int k = 0; k < n; k++)
                send_beat(mmi_pkg::CMD_LOAD_A, i, k, rand_value());
        for (int k = 0; k < n; k++)
            for (int j = 0; j < p; j++)
                send_beat(mmi_pkg::CMD_LOAD_B, k, j, rand_value());
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each result beat taken
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_beat(m_tdata, m_tlast, m_tuser);
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT && !done)
        begin
            $display("matrix_multiply_int_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        int m, n, p, sent;
        board = new();
        cycles = 0;
        done = 0;
        hold_off = 0;
        send_idle_pct = 29;
        recv_idle_pct = 29;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset dims 1x1x1 with extreme values, ignored beats
        send_beat(mmi_pkg::CMD_LOAD_A, 0, 0, 32'h80000000);
        send_beat(mmi_pkg::CMD_LOAD_B, 0, 0, 32'hffffffff);
        send_beat(mmi_pkg::CMD_NONE, 7, 7, 32'hffffffff);
        send_beat(mmi_pkg::CMD_START, 7, 7, 32'hffffffff);
        send_beat(mmi_pkg::CMD_LOAD_A, 0, 0, 32'h7fffffff);
        send_beat(mmi_pkg::CMD_START, 0, 0, 32'h0);
        drain();
        // Zero dimensions in each register
        set_dims(0, 1, 1);
        send_beat(mmi_pkg::CMD_START, 0, 0, 0);
        drain();
        set_dims(1, 0, 1);
        send_beat(mmi_pkg::CMD_START, 0, 0, 0);
        drain();
        set_dims(1, 1, 0);
        send_beat(mmi_pkg::CMD_START, 0, 0, 0);
        drain();
        // Oversized dimensions clamp to 8; full stores, under a long output stall
        set_dims(15, 15, 15);
        load_mats(8, 8, 8);
        send_beat(mmi_pkg::CMD_START, 0, 0, 0);
        hold_off <= 300;
        send_beat(mmi_pkg::CMD_LOAD_A, 7, 7, 32'h12345678);
        send_beat(mmi_pkg::CMD_LOAD_B, 7, 7, 32'h87654321);
        drain();

        // Random phases of well-formed load/start sequences with noise
        sent = 0;
        while (sent < 200)
        begin
            m = $urandom_range(1, 4);
            n = $urandom_range(1, 4);
            p = $urandom_range(1, 4);
            if ($urandom_range(9) == 0)
                m = 8;
            send_idle_pct = ($urandom_range(3) == 0) ? 0 : 29;
            recv_idle_pct = ($urandom_range(3) == 0) ? 0 : 29;
            drain();
            set_dims(m, n, p);
            load_mats(m, n, p);
            sent += m * n + n * p;
            for (int t = 0; t < 3; t++)
            begin
                case ($urandom_range(3))
                    0: send_beat(mmi_pkg::CMD_NONE, $urandom_range(7), $urandom_range(7),
                        $urandom);
                    1: send_beat(mmi_pkg::cmd_t'($urandom_range(1)), $urandom_range(7),
                        $urandom_range(7), rand_value());
                    default: send_beat(mmi_pkg::CMD_START, $urandom_range(7),
                        $urandom_range(7), $urandom);
                endcase
                sent++;
            end
            send_beat(mmi_pkg::CMD_START, 0, 0, 0);
            sent++;
        end
        drain();
        send_idle_pct = 29;
        recv_idle_pct = 29;

        // Final wait for stragglers
        while (board.want_data.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        done = 1;
        if (board.errors == 0 && board.want_data.size() == 0)
            $display("matrix_multiply_int_test OK");
        else
            $display("matrix_multiply_int_test NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mmi_pkg.sv
design/mmi_mac_cell.sv
design/matrix_multiply_int.sv
design/mmi_checker.sv
bench/matrix_multiply_int_test.sv
